### design/tlwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tlwc_pkg
// Shared constants, types and register indexes of the two-level write-back cache.
// -----------------------------------------------------------------------------
package tlwc_pkg;

   localparam int BLOCK_WORDS = 16;
   localparam int L1_LINES    = 256;
   localparam int L2_SETS     = 256;
   localparam int L2_WAYS     = 2;
   localparam int MEM_WORDS   = 16384;

   localparam int ADDR_W  = $clog2(MEM_WORDS);
   localparam int OFF_W   = $clog2(BLOCK_WORDS);
   localparam int L1_IDX_W = $clog2(L1_LINES);
   localparam int L2_SET_W = $clog2(L2_SETS);
   localparam int L1_TAG_W = ADDR_W - OFF_W - L1_IDX_W;
   localparam int L2_TAG_W = ADDR_W - OFF_W - L2_SET_W;
   localparam int L1_WORDS = L1_LINES * BLOCK_WORDS;
   localparam int L2_SLOTS = L2_SETS * L2_WAYS;
   localparam int L2_SLOT_W = $clog2(L2_SLOTS);
   localparam int L2_WORDS = L2_SLOTS * BLOCK_WORDS;
   localparam int CNT_W    = OFF_W + 1;
   localparam int MEM_CLR_W = ADDR_W + 1;
   localparam int WORD_W   = 32;
   localparam int COST_W   = 10;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_L1_READ   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_L1_WRITE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_L2_READ   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_L2_WRITE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MEM_READ  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MEM_WRITE = 3'd5;

   // which cost the shared adder adds in a given step
   typedef enum logic [2:0] {
      COST_L1_READ   = 3'd0,
      COST_L1_WRITE  = 3'd1,
      COST_L2_READ   = 3'd2,
      COST_L2_WRITE  = 3'd3,
      COST_MEM_READ  = 3'd4,
      COST_MEM_WRITE = 3'd5
   } cost_sel_type;

   typedef struct packed {
      logic [COST_W-1:0] l1_read;
      logic [COST_W-1:0] l1_write;
      logic [COST_W-1:0] l2_read;
      logic [COST_W-1:0] l2_write;
      logic [COST_W-1:0] mem_read;
      logic [COST_W-1:0] mem_write;
   } costs_type;

   typedef struct packed {
      logic         add;
      cost_sel_type sel;
   } time_ctl_type;

endpackage
`default_nettype wire

### design/tlwc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tlwc_ram
// Generic single-port RAM with registered read data.
// -----------------------------------------------------------------------------
module tlwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

### design/tlwc_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tlwc_timer
// Cost registers and the shared accumulate unit for the running access time.
// -----------------------------------------------------------------------------
module tlwc_timer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [tlwc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tlwc_pkg::COST_W-1:0]          csr_wdata,
   input  wire tlwc_pkg::time_ctl_type               ctl,
   output logic      [tlwc_pkg::WORD_W-1:0]          total
);
   tlwc_pkg::costs_type costs_ff;
   logic [tlwc_pkg::WORD_W-1:0] total_ff, total_in;
   logic [tlwc_pkg::COST_W-1:0] cost;

   always_comb begin
      case (ctl.sel)
         tlwc_pkg::COST_L1_READ:   cost = costs_ff.l1_read;
         tlwc_pkg::COST_L1_WRITE:  cost = costs_ff.l1_write;
         tlwc_pkg::COST_L2_READ:   cost = costs_ff.l2_read;
         tlwc_pkg::COST_L2_WRITE:  cost = costs_ff.l2_write;
         tlwc_pkg::COST_MEM_READ:  cost = costs_ff.mem_read;
         tlwc_pkg::COST_MEM_WRITE: cost = costs_ff.mem_write;
         default:                  cost = '0;
      endcase
      total_in = total_ff;
      if (ctl.add) begin
         total_in = total_ff + {{(tlwc_pkg::WORD_W-tlwc_pkg::COST_W){1'b0}}, cost};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         costs_ff.l1_read   <= 10'd1;
         costs_ff.l1_write  <= 10'd1;
         costs_ff.l2_read   <= 10'd10;
         costs_ff.l2_write  <= 10'd10;
         costs_ff.mem_read  <= 10'd100;
         costs_ff.mem_write <= 10'd50;
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
         if (csr_we) begin
            case (csr_index)
               tlwc_pkg::REG_L1_READ:   costs_ff.l1_read   <= csr_wdata;
               tlwc_pkg::REG_L1_WRITE:  costs_ff.l1_write  <= csr_wdata;
               tlwc_pkg::REG_L2_READ:   costs_ff.l2_read   <= csr_wdata;
               tlwc_pkg::REG_L2_WRITE:  costs_ff.l2_write  <= csr_wdata;
               tlwc_pkg::REG_MEM_READ:  costs_ff.mem_read  <= csr_wdata;
               tlwc_pkg::REG_MEM_WRITE: costs_ff.mem_write <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign total = total_ff;
endmodule
`default_nettype wire

### design/two_level_writeback_cache_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// two_level_writeback_cache_unit
// Direct-mapped L1 in front of a 2-way LRU L2 and a main memory, all write-back.
// -----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one word read or write per transaction; rsp_ returns
//   one transaction per request with the word read, hit flags and the running
//   access-time total. csr_ writes the six cost registers; the user must write
//   them only while idle, since the block itself does not enforce it. A
//   sequencer moves blocks one word per cycle through the single-port RAMs of
//   L1, L2 and main memory. An L1 hit passes the L1 tag lookup and the word
//   access before rsp_tvalid. An L1 miss adds an L2 tag lookup plus one block
//   move per L2 access (L1 victim writeback, fill), and an L2 miss adds one or
//   two memory block moves. Worst case is six block moves. One request is in
//   flight at a time.
// Reset:
//   costs and the total return to reset values. Main memory and the L1 and L2
//   tag stores are then cleared entry by entry before req_tready rises.
// Stall:
//   the result sits in an output register until rsp_tready; the next request
//   can be taken in the cycle after it leaves.
// -----------------------------------------------------------------------------
module two_level_writeback_cache_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // word_address[13:0], write_data[45:14]
   input  wire logic        req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [71:0] rsp_tdata,   // read_data, l1_hit, l2_hit, elapsed_time
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_wdata
);
   localparam int AW = tlwc_pkg::ADDR_W;
   localparam int OW = tlwc_pkg::OFF_W;
   localparam int IW = tlwc_pkg::L1_IDX_W;
   localparam int SW = tlwc_pkg::L2_SET_W;
   localparam int T1 = tlwc_pkg::L1_TAG_W;
   localparam int T2 = tlwc_pkg::L2_TAG_W;
   localparam int WW = tlwc_pkg::WORD_W;
   localparam int CW = tlwc_pkg::CNT_W;
   localparam int ME = T2 + 2;   // l2 way entry: tag, valid, dirty

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b00000000001,
      ST_IDLE   = 11'b00000000010,
      ST_LOOK1  = 11'b00000000100,
      ST_L2REQ  = 11'b00000001000,
      ST_L2LOOK = 11'b00000010000,
      ST_MEMWB  = 11'b00000100000,
      ST_MEMRD  = 11'b00001000000,
      ST_L2XFER = 11'b00010000000,
      ST_WORD   = 11'b00100000000,
      ST_WORD2  = 11'b01000000000,
      ST_RESP   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // request registers
   logic          wr_ff;
   logic [AW-1:0] addr_ff;
   logic [WW-1:0] wdata_ff;
   logic [WW-1:0] rdata_ff;
   logic          l1h_ff, l2h_ff;

   // current L2 block operation
   logic          op_wr_ff;      // 1: block goes L1 -> L2
   logic [AW-OW-1:0] op_blk_ff;  // block number
   logic          op_hit_ff;
   logic          op_way_ff;
   logic          pend_fill_ff;  // fill after victim writeback
   logic          mem_phase_ff;  // memory op: 0 writeback, 1 read
   logic [AW-OW-1:0] mem_blk_ff;

   logic [CW-1:0] cnt_ff;        // issue counter
   logic          rd_v_ff;       // a read issued last cycle
   logic [OW-1:0] rd_off_ff;
   logic [AW-1:0] clr_ff;

   tlwc_pkg::time_ctl_type tctl;
   logic [WW-1:0] total;

   // RAM ports
   logic l1_we, l2_we, mm_we;
   logic [$clog2(tlwc_pkg::L1_WORDS)-1:0] l1_a;
   logic [$clog2(tlwc_pkg::L2_WORDS)-1:0] l2_a;
   logic [AW-1:0] mm_a;
   logic [WW-1:0] l1_wd, l2_wd, mm_wd, l1_rd, l2_rd, mm_rd;

   // tag stores: l1 line {tag, valid, dirty}; l2 set {lru, way1, way0}
   logic          l1m_we, l2m_we;
   logic [IW-1:0] l1m_a;
   logic [SW-1:0] l2m_a;
   logic [T1+1:0] l1m_wd, l1m_rd;
   logic [2*ME:0] l2m_wd, l2m_rd, l2m_new;

   tlwc_ram #(.WIDTH(WW), .DEPTH(tlwc_pkg::L1_WORDS)) u_l1 (
      .clock(clock), .we(l1_we), .addr(l1_a), .wdata(l1_wd), .rdata(l1_rd));
   tlwc_ram #(.WIDTH(WW), .DEPTH(tlwc_pkg::L2_WORDS)) u_l2 (
      .clock(clock), .we(l2_we), .addr(l2_a), .wdata(l2_wd), .rdata(l2_rd));
   tlwc_ram #(.WIDTH(WW), .DEPTH(tlwc_pkg::MEM_WORDS)) u_mm (
      .clock(clock), .we(mm_we), .addr(mm_a), .wdata(mm_wd), .rdata(mm_rd));
   tlwc_ram #(.WIDTH(T1+2), .DEPTH(tlwc_pkg::L1_LINES)) u_l1m (
      .clock(clock), .we(l1m_we), .addr(l1m_a), .wdata(l1m_wd), .rdata(l1m_rd));
   tlwc_ram #(.WIDTH(2*ME+1), .DEPTH(tlwc_pkg::L2_SETS)) u_l2m (
      .clock(clock), .we(l2m_we), .addr(l2m_a), .wdata(l2m_wd), .rdata(l2m_rd));

   tlwc_timer u_timer (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .ctl(tctl), .total(total));

   logic [OW-1:0] offs;
   logic [IW-1:0] line;
   logic [T1-1:0] tag1;
   logic [SW-1:0] oset;
   logic [T2-1:0] otag;
   logic [tlwc_pkg::L2_SLOT_W-1:0] vslot;
   logic [ME-1:0] way0, way1, sel_ent;
   logic          hit0, hit1, l1_hit_now, l2_hit_now, way_sel, vdirty;
   logic [AW-OW-1:0] l1_vblk;
   logic          cnt_done;

   assign offs = addr_ff[OW-1:0];
   assign line = addr_ff[OW +: IW];
   assign tag1 = addr_ff[AW-1 -: T1];
   assign oset = op_blk_ff[SW-1:0];
   assign otag = op_blk_ff[AW-OW-1 -: T2];
   assign way0 = l2m_rd[ME-1:0];
   assign way1 = l2m_rd[2*ME-1:ME];
   assign hit0 = way0[1] && (way0[ME-1:2] == otag);
   assign hit1 = way1[1] && (way1[ME-1:2] == otag);
   assign l2_hit_now = hit0 || hit1;
   // on a miss the lru bit names the victim way
   assign way_sel = l2_hit_now ? hit1 : l2m_rd[2*ME];
   assign sel_ent = way_sel ? way1 : way0;
   assign vdirty = sel_ent[1] && sel_ent[0];
   assign vslot = {oset, op_way_ff};
   assign l1_hit_now = l1m_rd[1] && (l1m_rd[T1+1:2] == tag1);
   assign l1_vblk = {l1m_rd[T1+1:2], line};
   assign cnt_done = (cnt_ff == CW'(tlwc_pkg::BLOCK_WORDS));

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {6'd0, total, l2h_ff, l1h_ff, rdata_ff};

   // final set entry after this l2 access, written once at lookup
   always_comb begin
      l2m_new = l2m_rd;
      l2m_new[2*ME] = ~way_sel;
      if (way_sel) begin
         l2m_new[2*ME-1:ME] = {otag, 1'b1, op_wr_ff | (l2_hit_now & sel_ent[0])};
      end else begin
         l2m_new[ME-1:0] = {otag, 1'b1, op_wr_ff | (l2_hit_now & sel_ent[0])};
      end
   end

   // datapath addressing: reads issue at cnt_ff, writes land at rd_off_ff
   always_comb begin
      l1_we = 1'b0; l2_we = 1'b0; mm_we = 1'b0;
      l1_a  = {line, cnt_ff[OW-1:0]};
      l2_a  = {vslot, cnt_ff[OW-1:0]};
      mm_a  = AW'({mem_blk_ff, cnt_ff[OW-1:0]});
      l1_wd = l2_rd; l2_wd = l1_rd; mm_wd = l2_rd;
      l1m_we = 1'b0;
      l1m_a  = line;
      l1m_wd = {tag1, 1'b1, wr_ff | (l1h_ff & l1m_rd[0])};
      l2m_we = 1'b0;
      l2m_a  = oset;
      l2m_wd = l2m_new;
      tctl.add = 1'b0;
      tctl.sel = tlwc_pkg::COST_L1_READ;
      case (state_ff)
         ST_CLEAR: begin
            mm_we  = 1'b1;
            mm_a   = clr_ff;
            mm_wd  = '0;
            l1m_we = 1'b1;
            l1m_a  = clr_ff[IW-1:0];
            l1m_wd = '0;
            l2m_we = 1'b1;
            l2m_a  = clr_ff[SW-1:0];
            l2m_wd = '0;
         end
         // tag read lands in the lookup cycle right after acceptance
         ST_IDLE: l1m_a = req_tdata[OW +: IW];
         ST_L2LOOK: l2m_we = 1'b1;
         ST_L2XFER: begin
            if (op_wr_ff) begin
               // L1 -> L2
               if (rd_v_ff) begin
                  l2_we = 1'b1;
                  l2_a  = {vslot, rd_off_ff};
               end
            end else if (rd_v_ff) begin
               l1_we = 1'b1;
               l1_a  = {line, rd_off_ff};
            end
            if (!rd_v_ff && cnt_done) begin
               tctl.add = 1'b1;
               tctl.sel = op_wr_ff ? tlwc_pkg::COST_L2_WRITE : tlwc_pkg::COST_L2_READ;
            end
         end
         ST_MEMWB, ST_MEMRD: begin
            if (mem_phase_ff) begin
               // memory -> L2
               mm_a = AW'({mem_blk_ff, cnt_ff[OW-1:0]});
               l2_wd = mm_rd;
               if (rd_v_ff) begin
                  l2_we = 1'b1;
                  l2_a  = {vslot, rd_off_ff};
               end
            end else if (rd_v_ff) begin
               mm_we = 1'b1;
               mm_a  = AW'({mem_blk_ff, rd_off_ff});
            end
            if (!rd_v_ff && cnt_done) begin
               tctl.add = 1'b1;
               tctl.sel = mem_phase_ff ? tlwc_pkg::COST_MEM_READ
                                       : tlwc_pkg::COST_MEM_WRITE;
            end
         end
         ST_WORD: begin
            l1_a  = {line, offs};
            l1_we = wr_ff;
            l1_wd = wdata_ff;
            l1m_we = 1'b1;
            tctl.add = 1'b1;
            tctl.sel = wr_ff ? tlwc_pkg::COST_L1_WRITE : tlwc_pkg::COST_L1_READ;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(tlwc_pkg::MEM_WORDS - 1))
            state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_LOOK1;
         ST_LOOK1:  state_in = l1_hit_now ? ST_WORD : ST_L2REQ;
         ST_L2REQ:  state_in = ST_L2LOOK;
         ST_L2LOOK: begin
            if (l2_hit_now) state_in = ST_L2XFER;
            else if (vdirty) state_in = ST_MEMWB;
            else state_in = ST_MEMRD;
         end
         ST_MEMWB:  if (!rd_v_ff && cnt_done) state_in = ST_MEMRD;
         ST_MEMRD:  if (!rd_v_ff && cnt_done) state_in = ST_L2XFER;
         ST_L2XFER: if (!rd_v_ff && cnt_done) state_in = pend_fill_ff ? ST_L2REQ : ST_WORD;
         ST_WORD:   state_in = ST_WORD2;
         ST_WORD2:  state_in = ST_RESP;
         ST_RESP:   if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         rd_v_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            ST_IDLE: begin
               wr_ff    <= req_tuser;
               addr_ff  <= req_tdata[AW-1:0];
               wdata_ff <= req_tdata[AW +: WW];
            end
            ST_LOOK1: begin
               l1h_ff <= l1_hit_now;
               l2h_ff <= 1'b0;
               if (!l1_hit_now) begin
                  if (l1m_rd[1] && l1m_rd[0]) begin
                     op_wr_ff     <= 1'b1;
                     op_blk_ff    <= l1_vblk;
                     pend_fill_ff <= 1'b1;
                  end else begin
                     op_wr_ff     <= 1'b0;
                     op_blk_ff    <= addr_ff[AW-1:OW];
                     pend_fill_ff <= 1'b0;
                  end
               end
            end
            ST_L2REQ: ;
            ST_L2LOOK: begin
               cnt_ff       <= '0;
               rd_v_ff      <= 1'b0;
               op_hit_ff    <= l2_hit_now;
               op_way_ff    <= way_sel;
               mem_phase_ff <= !vdirty;
               mem_blk_ff   <= vdirty ? {sel_ent[ME-1:2], oset} : op_blk_ff;
            end
            ST_MEMWB, ST_MEMRD, ST_L2XFER: begin
               // one word read issued per cycle, written the next
               if (!cnt_done) begin
                  cnt_ff    <= cnt_ff + 1'b1;
                  rd_v_ff   <= 1'b1;
                  rd_off_ff <= cnt_ff[OW-1:0];
               end else begin
                  rd_v_ff <= 1'b0;
               end
               if (!rd_v_ff && cnt_done) begin
                  cnt_ff <= '0;
                  if (state_ff == ST_MEMWB) begin
                     mem_phase_ff <= 1'b1;
                     mem_blk_ff   <= op_blk_ff;
                  end else if (state_ff == ST_L2XFER) begin
                     if (op_wr_ff) begin
                        op_wr_ff     <= 1'b0;
                        op_blk_ff    <= addr_ff[AW-1:OW];
                        pend_fill_ff <= 1'b0;
                     end else begin
                        l2h_ff <= op_hit_ff;
                     end
                  end
               end
            end
            ST_WORD2: rdata_ff <= wr_ff ? '0 : l1_rd;
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### design/tlwc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tlwc_checker
// Port-level checks on the cache unit, bound to the top level.
// -----------------------------------------------------------------------------
module tlwc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);
   // one transaction in flight: never ready for a request while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("req ready while rsp pending");

   // an accepted request is never answered in the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid) else $error("rsp too early");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp changed under stall");

   // l2 hit flag only on an l1 miss
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[33])) else $error("bad hit flags");
endmodule

bind two_level_writeback_cache_unit tlwc_checker u_tlwc_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire

### tb/two_level_writeback_cache_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// two_level_writeback_cache_unit_tb
// Self-checking bench for the two-level write-back cache: a behavioral cache
// model predicts read data, hit flags and the running access time for every
// request, and the monitor compares each response against it in order.
// -----------------------------------------------------------------------------
module two_level_writeback_cache_unit_tb;

   typedef struct packed {
      logic        is_write;
      logic [13:0] addr;
      logic [31:0] wdata;
   } access_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        l1h;
      logic        l2h;
      logic [31:0] total;
   } outcome_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   two_level_writeback_cache_unit dut (.*);

   always #5 clock = ~clock;

   // model state
   logic [9:0]  cost [6];
   logic [31:0] m_l1 [tlwc_pkg::L1_WORDS];
   logic [1:0]  m_l1_tag [tlwc_pkg::L1_LINES];
   logic        m_l1_v [tlwc_pkg::L1_LINES];
   logic        m_l1_d [tlwc_pkg::L1_LINES];
   logic [31:0] m_l2 [tlwc_pkg::L2_WORDS];
   logic [1:0]  m_l2_tag [tlwc_pkg::L2_SLOTS];
   logic        m_l2_v [tlwc_pkg::L2_SLOTS];
   logic        m_l2_d [tlwc_pkg::L2_SLOTS];
   logic        m_lru [tlwc_pkg::L2_SETS];
   logic [31:0] m_mem [tlwc_pkg::MEM_WORDS];
   logic [31:0] m_total;

   access_type  pending_q [$];
   outcome_type awaited_q [$];
   int errors = 0;
   int sent = 0;
   int seen = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off = 0;
   logic hold_arm = 0;
   logic hold_used = 0;
   int l1_hits = 0, l2_hits = 0, dirty_evicts = 0;

   // block move between l1 line and l2; returns l2 hit
   function automatic bit l2_move(int base, int line, bit is_write);
      int set, slot, vbase;
      logic [1:0] tg;
      bit hit;
      set = (base / tlwc_pkg::BLOCK_WORDS) % tlwc_pkg::L2_SETS;
      tg = 2'(base / (tlwc_pkg::L2_SETS * tlwc_pkg::BLOCK_WORDS));
      hit = 0;
      slot = 0;
      for (int w = 0; w < tlwc_pkg::L2_WAYS; w++)
         if (!hit && m_l2_v[set*2+w] && m_l2_tag[set*2+w] == tg) begin
            hit = 1;
            slot = set*2 + w;
         end
      if (!hit) begin
         slot = set*2 + int'(m_lru[set]);
         if (m_l2_v[slot] && m_l2_d[slot]) begin
            vbase = (int'(m_l2_tag[slot]) * tlwc_pkg::L2_SETS + set) * tlwc_pkg::BLOCK_WORDS;
            for (int i = 0; i < tlwc_pkg::BLOCK_WORDS; i++)
               m_mem[(vbase + i) % tlwc_pkg::MEM_WORDS] =
                  m_l2[slot*tlwc_pkg::BLOCK_WORDS + i];
            m_total += 32'(cost[tlwc_pkg::REG_MEM_WRITE]);
            dirty_evicts++;
         end
         for (int i = 0; i < tlwc_pkg::BLOCK_WORDS; i++)
            m_l2[slot*tlwc_pkg::BLOCK_WORDS + i] = m_mem[(base + i) % tlwc_pkg::MEM_WORDS];
         m_total += 32'(cost[tlwc_pkg::REG_MEM_READ]);
         m_l2_v[slot] = 1;
         m_l2_d[slot] = 0;
         m_l2_tag[slot] = tg;
      end
      for (int i = 0; i < tlwc_pkg::BLOCK_WORDS; i++)
         if (is_write)
            m_l2[slot*tlwc_pkg::BLOCK_WORDS + i] = m_l1[line*tlwc_pkg::BLOCK_WORDS + i];
         else
            m_l1[line*tlwc_pkg::BLOCK_WORDS + i] = m_l2[slot*tlwc_pkg::BLOCK_WORDS + i];
      if (is_write) begin
         m_l2_d[slot] = 1;
         m_total += 32'(cost[tlwc_pkg::REG_L2_WRITE]);
      end else begin
         m_total += 32'(cost[tlwc_pkg::REG_L2_READ]);
      end
      m_lru[set] = ~slot[0];
      return hit;
   endfunction

   function automatic outcome_type cache_access(access_type a);
      outcome_type o;
      int off, line;
      logic [1:0] tg;
      off = int'(a.addr) % tlwc_pkg::BLOCK_WORDS;
      line = (int'(a.addr) / tlwc_pkg::BLOCK_WORDS) % tlwc_pkg::L1_LINES;
      tg = 2'(int'(a.addr) / (tlwc_pkg::L1_LINES * tlwc_pkg::BLOCK_WORDS));
      o = '0;
      if (m_l1_v[line] && m_l1_tag[line] == tg) begin
         o.l1h = 1;
      end else begin
         if (m_l1_v[line] && m_l1_d[line])
            void'(l2_move((int'(m_l1_tag[line]) * tlwc_pkg::L1_LINES + line)
                          * tlwc_pkg::BLOCK_WORDS, line, 1));
         o.l2h = l2_move(int'(a.addr) - off, line, 0);
         m_l1_v[line] = 1;
         m_l1_d[line] = 0;
         m_l1_tag[line] = tg;
      end
      if (a.is_write) begin
         m_l1[line*tlwc_pkg::BLOCK_WORDS + off] = a.wdata;
         m_l1_d[line] = 1;
         m_total += 32'(cost[tlwc_pkg::REG_L1_WRITE]);
      end else begin
         o.rdata = m_l1[line*tlwc_pkg::BLOCK_WORDS + off];
         m_total += 32'(cost[tlwc_pkg::REG_L1_READ]);
      end
      o.total = m_total;
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (req_tvalid) sent++;
            if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               access_type a;
               a = pending_q.pop_front();
               req_tvalid <= 1;
               req_tuser <= a.is_write;
               req_tdata <= {2'b00, a.wdata, a.addr};
               awaited_q.push_back(cache_access(a));
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // receiver ready, with one long hold-off counted here
   always @(posedge clock) begin
      if (hold_arm && !hold_used) begin
         hold_used <= 1;
         hold_off <= 3000;
         rsp_tready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         outcome_type got, exp;
         got = {rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[33], rsp_tdata[65:34]};
         seen++;
         if (awaited_q.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            exp = awaited_q.pop_front();
            if (got.l1h) l1_hits++;
            if (got.l2h) l2_hits++;
            if (got.rdata !== exp.rdata) begin
               $error("read_data expected %h got %h", exp.rdata, got.rdata);
               errors++;
            end
            if (got.l1h !== exp.l1h) begin
               $error("l1_hit expected %b got %b", exp.l1h, got.l1h);
               errors++;
            end
            if (got.l2h !== exp.l2h) begin
               $error("l2_hit expected %b got %b", exp.l2h, got.l2h);
               errors++;
            end
            if (got.total !== exp.total) begin
               $error("elapsed_time expected %h got %h", exp.total, got.total);
               errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_q.size() > 0 || req_tvalid || awaited_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_cost(logic [2:0] idx, logic [9:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      cost[idx] = val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic access_type rand_access(int region);
      access_type a;
      a.is_write = 1'($urandom_range(1, 0));
      a.wdata = $urandom();
      // a small pool of blocks forces conflicts in both levels
      case (region)
         0: a.addr = 14'($urandom_range(16383, 0));
         default: a.addr = {2'($urandom_range(3, 0)), $urandom_range(3, 0) == 0 ?
                            8'($urandom_range(255, 0)) : 8'($urandom_range(3, 0)),
                            4'($urandom_range(15, 0))};
      endcase
      return a;
   endfunction

   // the first touch of every line is a fill, so reads never see stale cache data
   task automatic push(bit w, logic [13:0] ad, logic [31:0] d);
      access_type a;
      a.is_write = w;
      a.addr = ad;
      a.wdata = d;
      pending_q.push_back(a);
   endtask

   initial begin
      cost[0] = 1; cost[1] = 1; cost[2] = 10; cost[3] = 10; cost[4] = 100; cost[5] = 50;
      m_total = 0;
      for (int i = 0; i < tlwc_pkg::L1_LINES; i++) begin
         m_l1_v[i] = 0; m_l1_d[i] = 0; m_l1_tag[i] = 0;
      end
      for (int i = 0; i < tlwc_pkg::L2_SLOTS; i++) begin
         m_l2_v[i] = 0; m_l2_d[i] = 0; m_l2_tag[i] = 0;
      end
      for (int i = 0; i < tlwc_pkg::L2_SETS; i++) m_lru[i] = 0;
      for (int i = 0; i < tlwc_pkg::MEM_WORDS; i++) m_mem[i] = 0;
      for (int i = 0; i < tlwc_pkg::L1_WORDS; i++) m_l1[i] = 0;
      for (int i = 0; i < tlwc_pkg::L2_WORDS; i++) m_l2[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: reset costs, extremes, l1 and l2 hits, dirty evictions in both levels
      push(0, 14'h0000, 32'h0);
      push(1, 14'h0000, 32'hFFFF_FFFF);
      push(0, 14'h0000, 32'h0);
      push(1, 14'h3FFF, 32'hA5A5_5A5A);
      push(0, 14'h3FFF, 32'h0);
      push(1, 14'h1000, 32'h1234_5678);   // evicts dirty line 0 into l2
      push(0, 14'h0005, 32'h0);           // l2 hit
      push(1, 14'h2000, 32'hDEAD_BEEF);   // set 0 both ways busy
      push(1, 14'h3000, 32'hCAFE_F00D);
      push(0, 14'h1000, 32'h0);
      push(0, 14'h0000, 32'h0);
      push(0, 14'h2000, 32'h0);
      push(0, 14'h3000, 32'h0);
      push(1, 14'h0FF0, 32'h5555_5555);
      push(0, 14'h1FFF, 32'h0);
      push(0, 14'h0FFF, 32'h0);
      wait_drained();

      set_cost(tlwc_pkg::REG_L1_READ, 10'd0);
      set_cost(tlwc_pkg::REG_L1_WRITE, 10'd0);
      set_cost(tlwc_pkg::REG_L2_READ, 10'd0);
      set_cost(tlwc_pkg::REG_L2_WRITE, 10'd0);
      set_cost(tlwc_pkg::REG_MEM_READ, 10'd0);
      set_cost(tlwc_pkg::REG_MEM_WRITE, 10'd0);
      for (int i = 0; i < 6; i++) pending_q.push_back(rand_access(1));
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         for (int r = 0; r < 6; r++)
            set_cost(r[2:0], phase == 0 ? 10'h3FF : 10'($urandom_range(1023, 0)));
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            3: begin send_idle_pct = 9;  stall_pct = 9;  end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         if (phase == 4) hold_arm = 1;
         for (int i = 0; i < 200; i++) pending_q.push_back(rand_access(i % 4 == 0 ? 0 : 1));
         wait_drained();
      end

      $display("covered %0d requests sent, %0d answered: %0d l1 hits, %0d l2 hits, %0d dirty l2 evictions",
               sent, seen, l1_hits, l2_hits, dirty_evicts);
      $display("cost settings: reset values, all zero, all max and random; four idle mixes");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("timed out waiting for responses");
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

### two_level_writeback_cache_unit.f
design/tlwc_pkg.sv
design/tlwc_ram.sv
design/tlwc_timer.sv
design/two_level_writeback_cache_unit.sv
design/tlwc_checker.sv
tb/two_level_writeback_cache_unit_tb.sv
